// File: rtl/best_times_top_k_assert.svh
// ----------------------------------------------------------------------------
// best_times_top_k_assert.svh
// Assertion macros shared by the best-times block.
// ----------------------------------------------------------------------------
`ifndef BEST_TIMES_TOP_K_ASSERT_SVH
`define BEST_TIMES_TOP_K_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BTK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BTK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/btk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btk_pkg
// Types and constants of the best-times block.
// ----------------------------------------------------------------------------
package btk_pkg;

  localparam int TIME_W = 16;
  localparam int MODE_W = 2;
  localparam int RANK_W = 4;

  // Function codes of an input beat
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LIST   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FULL_RD,
    ST_FULL_CMP,
    ST_SHIFT_RD,
    ST_SHIFT,
    ST_LIST_RD,
    ST_LIST_OUT,
    ST_EMPTY
  } state_e;

endpackage

// File: rtl/best_times_top_k.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_times_top_k
// Per-mode sorted lists of the smallest finishing times.
// ----------------------------------------------------------------------------
// The block keeps NUM_LISTS sorted lists (mode 1 to NUM_LISTS) of up to
// LIST_DEPTH times each, all held in one RAM with registered read data;
// only the per-list fill counts live in flip-flops, so no clearing pass is
// needed after reset. An insert beat (func 0) walks down the chosen list
// from its end, moving each larger entry up one slot per cycle, and drops
// the new time into the gap; on a full list it first reads the largest
// entry and discards the new time unless it is strictly smaller. An insert
// is carried out by a read-compare-write walk through the RAM. A list beat
// (func 1) streams the entries in rank order, one result beat per cycle
// while the result side is free, after a first RAM read, the final beat
// marked by last_o; an empty list gives one beat with empty_res_o and
// last_o set and zero value and rank. Beats with mode 0 or above NUM_LISTS
// are accepted and dropped. One item is worked on at a time: in_ready_o is
// high only when the block is idle. Ranks are reported in four bits.
// ----------------------------------------------------------------------------
module best_times_top_k #(
  parameter int LIST_DEPTH = 10,
  parameter int NUM_LISTS  = 3
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        func_i,
  input  logic [btk_pkg::MODE_W-1:0]  mode_i,
  input  logic [btk_pkg::TIME_W-1:0]  time_value_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [btk_pkg::TIME_W-1:0]  entry_value_o,
  output logic [btk_pkg::RANK_W-1:0]  rank_o,
  output logic                        empty_res_o,
  output logic                        last_o
);

  `include "best_times_top_k_assert.svh"

  localparam int IW        = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW        = $clog2(LIST_DEPTH + 1);
  localparam int SW        = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int RAM_DEPTH = NUM_LISTS * LIST_DEPTH;
  localparam int AW        = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

  // --------------------------------------------------------------------------
  // State and datapath registers
  // --------------------------------------------------------------------------
  btk_pkg::state_e             state_q, state_d;
  logic [SW-1:0]               sel_q, sel_d;       // list being worked on
  logic [btk_pkg::TIME_W-1:0]  time_q, time_d;     // time being inserted
  logic [IW-1:0]               pos_q, pos_d;       // gap slot / listing index
  logic [CW-1:0]               lcnt_q, lcnt_d;     // length of the listed list
  logic [CW-1:0]               cnt_q [NUM_LISTS];  // fill count per list

  // output register
  logic                        out_valid_q;
  logic [btk_pkg::TIME_W-1:0]  entry_value_q;
  logic [btk_pkg::RANK_W-1:0]  rank_q;
  logic                        empty_q;
  logic                        last_q;

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  logic [btk_pkg::MODE_W-1:0] mode_m1;
  logic [SW-1:0]              in_sel;
  logic                       mode_ok;
  logic                       in_acc;
  logic [CW-1:0]              in_cnt;
  logic                       in_full;

  assign mode_m1 = mode_i - btk_pkg::MODE_W'(1);
  assign in_sel  = SW'(mode_m1);
  assign mode_ok = (mode_i != '0) && (32'(mode_i) <= NUM_LISTS);
  assign in_acc  = in_valid_i && in_ready_o;
  assign in_cnt  = mode_ok ? cnt_q[in_sel] : '0;
  assign in_full = (32'(in_cnt) == LIST_DEPTH);

  // --------------------------------------------------------------------------
  // Address and compare helpers
  // --------------------------------------------------------------------------
  logic [AW-1:0]              base_addr;
  logic [IW-1:0]              pos_m1, pos_m2, pos_p1;
  logic [CW-1:0]              pos_inc;
  logic                       list_last;
  logic                       out_free;
  logic [btk_pkg::TIME_W-1:0] ram_rdata;
  logic                       rd_gt_time;

  assign base_addr  = AW'(32'(sel_q) * LIST_DEPTH);
  assign pos_m1     = pos_q - IW'(1);
  assign pos_m2     = pos_q - IW'(2);
  assign pos_p1     = pos_q + IW'(1);
  assign pos_inc    = CW'(pos_q) + CW'(1);
  assign list_last  = (pos_inc == lcnt_q);
  assign out_free   = !out_valid_q || out_ready_i;
  assign rd_gt_time = (ram_rdata > time_q);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      btk_pkg::ST_IDLE: begin
        if (in_acc && mode_ok) begin
          if (func_i == btk_pkg::FUNC_LIST) begin
            state_d = (in_cnt == '0) ? btk_pkg::ST_EMPTY : btk_pkg::ST_LIST_RD;
          end else begin
            state_d = in_full ? btk_pkg::ST_FULL_RD : btk_pkg::ST_SHIFT_RD;
          end
        end
      end
      btk_pkg::ST_FULL_RD:  state_d = btk_pkg::ST_FULL_CMP;
      btk_pkg::ST_FULL_CMP: begin
        state_d = rd_gt_time ? btk_pkg::ST_SHIFT_RD : btk_pkg::ST_IDLE;
      end
      btk_pkg::ST_SHIFT_RD: begin
        state_d = (pos_q == '0) ? btk_pkg::ST_IDLE : btk_pkg::ST_SHIFT;
      end
      btk_pkg::ST_SHIFT: begin
        if (rd_gt_time) begin
          state_d = (pos_m1 == '0) ? btk_pkg::ST_SHIFT_RD : btk_pkg::ST_SHIFT;
        end else begin
          state_d = btk_pkg::ST_IDLE;
        end
      end
      btk_pkg::ST_LIST_RD:  state_d = btk_pkg::ST_LIST_OUT;
      btk_pkg::ST_LIST_OUT: begin
        if (out_free && list_last) begin
          state_d = btk_pkg::ST_IDLE;
        end
      end
      btk_pkg::ST_EMPTY: begin
        if (out_free) begin
          state_d = btk_pkg::ST_IDLE;
        end
      end
      default: state_d = btk_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs of the state machine: RAM controls, input ready, result load
  // --------------------------------------------------------------------------
  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [btk_pkg::TIME_W-1:0] ram_wdata;
  logic                       out_load;

  always_comb begin
    in_ready_o = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = base_addr + AW'(pos_q);
    ram_raddr  = base_addr + AW'(pos_q);
    ram_wdata  = time_q;
    out_load   = 1'b0;
    unique case (state_q)
      btk_pkg::ST_IDLE: in_ready_o = 1'b1;
      btk_pkg::ST_FULL_RD: begin
        // fetch the largest stored entry
        ram_re = 1'b1;
      end
      btk_pkg::ST_FULL_CMP: begin
      end
      btk_pkg::ST_SHIFT_RD: begin
        if (pos_q == '0) begin
          ram_we = 1'b1;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = base_addr + AW'(pos_m1);
        end
      end
      btk_pkg::ST_SHIFT: begin
        ram_we = 1'b1;
        if (rd_gt_time) begin
          // move the larger neighbor up and fetch the next one down
          ram_wdata = ram_rdata;
          if (pos_m1 != '0) begin
            ram_re    = 1'b1;
            ram_raddr = base_addr + AW'(pos_m2);
          end
        end
      end
      btk_pkg::ST_LIST_RD: begin
        ram_re = 1'b1;
      end
      btk_pkg::ST_LIST_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (!list_last) begin
            ram_re    = 1'b1;
            ram_raddr = base_addr + AW'(pos_p1);
          end
        end
      end
      btk_pkg::ST_EMPTY: out_load = out_free;
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath next values
  // --------------------------------------------------------------------------
  always_comb begin
    sel_d  = sel_q;
    time_d = time_q;
    pos_d  = pos_q;
    lcnt_d = lcnt_q;
    case (state_q)
      btk_pkg::ST_IDLE: begin
        if (in_acc) begin
          sel_d  = in_sel;
          time_d = time_value_i;
          lcnt_d = in_cnt;
          if (func_i == btk_pkg::FUNC_LIST) begin
            pos_d = '0;
          end else if (in_full) begin
            pos_d = IW'(LIST_DEPTH - 1);
          end else begin
            pos_d = IW'(in_cnt);
          end
        end
      end
      btk_pkg::ST_SHIFT: begin
        if (rd_gt_time) begin
          pos_d = pos_m1;
        end
      end
      btk_pkg::ST_LIST_OUT: begin
        if (out_load) begin
          pos_d = pos_p1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= btk_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q  <= sel_d;
    time_q <= time_d;
    pos_q  <= pos_d;
    lcnt_q <= lcnt_d;
  end

  // Grow the count on an insert into a list that still has room
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (in_acc && mode_ok && (func_i == btk_pkg::FUNC_INSERT) && !in_full) begin
      cnt_q[in_sel] <= in_cnt + CW'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Result register: hold a beat until taken, load the next one behind it
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (state_q == btk_pkg::ST_EMPTY) begin
        entry_value_q <= '0;
        rank_q        <= '0;
        empty_q       <= 1'b1;
        last_q        <= 1'b1;
      end else begin
        entry_value_q <= ram_rdata;
        rank_q        <= btk_pkg::RANK_W'(pos_inc);
        empty_q       <= 1'b0;
        last_q        <= list_last;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign entry_value_o = entry_value_q;
  assign rank_o        = rank_q;
  assign empty_res_o   = empty_q;
  assign last_o        = last_q;

  // --------------------------------------------------------------------------
  // List storage
  // --------------------------------------------------------------------------
  btk_ram #(
    .WIDTH (btk_pkg::TIME_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < NUM_LISTS; g++) begin : g_cnt_chk
    `BTK_ASSERT_IMP(a_cnt_bound, 1'b1, 32'(cnt_q[g]) <= LIST_DEPTH, "list count above depth")
  end

  `BTK_ASSERT_IMP(a_shift_pos, state_q == btk_pkg::ST_SHIFT, pos_q != '0, "shift at slot zero")

  `BTK_ASSERT_IMP(a_empty_beat, out_valid_q && empty_q,
                  last_q && (rank_q == '0) && (entry_value_q == '0), "bad empty beat")

  `BTK_ASSERT_NXT(a_list_end,
                  (state_q == btk_pkg::ST_LIST_OUT) && (state_d == btk_pkg::ST_IDLE),
                  out_valid_q && last_q, "listing ended without last")

endmodule

// File: rtl/btk_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btk_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module btk_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 30
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: bench/tb_best_times_top_k.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_best_times_top_k
// Self-checking bench for the per-mode best-times lists.
// ----------------------------------------------------------------------------
// A short directed table opens the run. It covers empty listings after reset,
// ignored mode-0 beats, one list filled past its depth with equal times and a
// drop on a tie, and the time extremes. A random run of inserts and listings
// follows, with idle cycles on both sides and one long hold-off on the result
// side. Each listing beat is checked against the expected beat of its table
// row if it has one, else against the bench's own shadow of the sorted lists.
// ----------------------------------------------------------------------------
module tb_best_times_top_k;

  localparam int DEPTH       = 10;
  localparam int LISTS       = 3;
  localparam int NUM_DIR     = 25;
  localparam int RAND_ITEMS  = 385;
  localparam int HOLD_CYCLES = 250;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYC   = 20;

  // one listing beat, as it leaves the block
  typedef struct packed {
    logic [btk_pkg::TIME_W-1:0] value;
    logic [btk_pkg::RANK_W-1:0] rank;
    logic                       empty;
    logic                       last;
  } listing_beat_t;

  // one row of the directed table; exp is used only when typed is set
  typedef struct packed {
    logic                       func;
    logic [btk_pkg::MODE_W-1:0] mode;
    logic [btk_pkg::TIME_W-1:0] tv;
    logic                       typed;
    listing_beat_t              exp;
  } stim_row_t;

  localparam listing_beat_t NO_BEAT    = '0;
  localparam listing_beat_t EMPTY_BEAT = '{value: '0, rank: '0, empty: 1'b1, last: 1'b1};

  logic                       clk_i;
  logic                       rst_ni        = 1'b0;
  logic                       in_valid_i    = 1'b0;
  logic                       in_ready_o;
  logic                       func_i        = btk_pkg::FUNC_INSERT;
  logic [btk_pkg::MODE_W-1:0] mode_i        = '0;
  logic [btk_pkg::TIME_W-1:0] time_value_i  = '0;
  logic                       out_valid_o;
  logic                       out_ready_i   = 1'b0;
  logic [btk_pkg::TIME_W-1:0] entry_value_o;
  logic [btk_pkg::RANK_W-1:0] rank_o;
  logic                       empty_res_o;
  logic                       last_o;

  // side info that travels with the offered beat
  logic              drv_typed = 1'b0;
  listing_beat_t     drv_exp   = '0;

  // shared flags between the sender and the receiver
  logic              steady    = 1'b0;
  logic              hold_req  = 1'b0;
  logic              hold_done = 1'b0;
  int                hold_left = 0;

  int                quiet_cycles = 0;
  int                mismatch_cnt = 0;

  // shadow copy of the lists and the listing beats still owed by the block
  logic [btk_pkg::TIME_W-1:0] ladder_tab [LISTS][DEPTH];
  int                         ladder_cnt [LISTS];
  listing_beat_t              listing_q [$];

  stim_row_t         dir_rows [NUM_DIR];

  best_times_top_k #(
    .LIST_DEPTH(DEPTH),
    .NUM_LISTS (LISTS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .mode_i       (mode_i),
    .time_value_i (time_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .entry_value_o(entry_value_o),
    .rank_o       (rank_o),
    .empty_res_o  (empty_res_o),
    .last_o       (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Put a time into one shadow list: on a full list keep it only when it
  // beats the largest entry, then shift larger entries up and drop it in.
  task automatic track_insert(input int sel, input logic [btk_pkg::TIME_W-1:0] t);
    int pos;
    if (ladder_cnt[sel] == DEPTH) begin
      if (t >= ladder_tab[sel][DEPTH-1]) return;
      pos = DEPTH - 1;
    end else begin
      pos = ladder_cnt[sel];
      ladder_cnt[sel]++;
    end
    while (pos > 0 && ladder_tab[sel][pos-1] > t) begin
      ladder_tab[sel][pos] = ladder_tab[sel][pos-1];
      pos--;
    end
    ladder_tab[sel][pos] = t;
  endtask

  // Queue the beats that a listing of one shadow list must produce.
  task automatic track_listing(input int sel);
    listing_beat_t b;
    if (ladder_cnt[sel] == 0) begin
      listing_q.push_back(EMPTY_BEAT);
      return;
    end
    for (int k = 0; k < ladder_cnt[sel]; k++) begin
      b.value = ladder_tab[sel][k];
      b.rank  = btk_pkg::RANK_W'(k + 1);
      b.empty = 1'b0;
      b.last  = (k + 1 == ladder_cnt[sel]);
      listing_q.push_back(b);
    end
  endtask

  // Offer one beat: idle at random first, then hold valid and payload
  // steady until the block takes it.
  task automatic offer_beat(input logic f, input logic [btk_pkg::MODE_W-1:0] m,
                            input logic [btk_pkg::TIME_W-1:0] t, input logic typed,
                            input listing_beat_t ex);
    while (!steady && $urandom_range(0, 99) < 28) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= f;
    mode_i       <= m;
    time_value_i <= t;
    drv_typed    <= typed;
    drv_exp      <= ex;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Receiver: a long hold-off once the sender asks for it, full rate in the
  // steady window, random stalls otherwise.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready_i <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      hold_done   <= 1'b1;
    end else if (steady) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= 28);
    end
  end

  // Monitor: check each result beat against the oldest owed beat first, then
  // advance the shadow lists with any input beat taken at this edge.
  always @(posedge clk_i) begin
    listing_beat_t want;
    int            sel;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (listing_q.size() == 0) begin
          $display("%0t: expected no beat, actual value=%0h rank=%0d empty=%0b last=%0b",
                   $time, entry_value_o, rank_o, empty_res_o, last_o);
          mismatch_cnt++;
        end else begin
          want = listing_q.pop_front();
          if (entry_value_o !== want.value) begin
            $display("%0t: entry_value expected %0h actual %0h",
                     $time, want.value, entry_value_o);
            mismatch_cnt++;
          end
          if (rank_o !== want.rank) begin
            $display("%0t: rank expected %0d actual %0d", $time, want.rank, rank_o);
            mismatch_cnt++;
          end
          if (empty_res_o !== want.empty) begin
            $display("%0t: empty_res expected %0b actual %0b",
                     $time, want.empty, empty_res_o);
            mismatch_cnt++;
          end
          if (last_o !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, last_o);
            mismatch_cnt++;
          end
        end
      end
      if (in_valid_i && in_ready_o && mode_i >= 1 && mode_i <= LISTS) begin
        sel = int'(mode_i) - 1;
        if (func_i == btk_pkg::FUNC_INSERT) begin
          track_insert(sel, time_value_i);
        end else if (drv_typed) begin
          listing_q.push_back(drv_exp);
        end else begin
          track_listing(sel);
        end
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a beat.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("CHECKS FAILED");
    $finish;
  end

  // Sender and run control.
  initial begin
    int                         kept;
    logic                       f;
    logic [btk_pkg::MODE_W-1:0] m;
    logic [btk_pkg::TIME_W-1:0] t;
    int                         sel;
    int                         top;

    for (int s = 0; s < LISTS; s++) begin
      ladder_cnt[s] = 0;
      for (int k = 0; k < DEPTH; k++) ladder_tab[s][k] = '0;
    end

    // Fill list 1 past its depth, with a repeated time, a replacement of the
    // largest entry, a tie with the largest that must be dropped, and a new
    // smallest that shifts the whole list.
    dir_rows = '{
      '{btk_pkg::FUNC_LIST,   2'd1, 16'h0000, 1'b1, EMPTY_BEAT},
      '{btk_pkg::FUNC_LIST,   2'd2, 16'h0000, 1'b1, EMPTY_BEAT},
      '{btk_pkg::FUNC_LIST,   2'd3, 16'h0000, 1'b1, EMPTY_BEAT},
      '{btk_pkg::FUNC_LIST,   2'd0, 16'h0000, 1'b0, NO_BEAT},
      '{btk_pkg::FUNC_INSERT, 2'd0, 16'hFFFF, 1'b0, NO_BEAT},
      '{btk_pkg::FUNC_LIST,   2'd1, 16'h0000, 1'b1, EMPTY_BEAT},
      '{btk_pkg::FUNC_INSERT, 2'd1, 16'hFFFF, 1'b0, NO_BEAT},
      '{btk_pkg::FUNC_LIST,   2'd1, 16'h0000, 1'b1, '{16'hFFFF, 4'd1, 1'b0, 1'b1}},
      '{btk_pkg::FUNC_INSERT, 2'd2, 16'h0000, 1'b0, NO_BEAT},
      '{btk_pkg::FUNC_LIST,   2'd2, 16'h0000, 1'b1, '{16'h0000, 4'd1, 1'b0, 1'b1}},
      '{btk_pkg::FUNC_INSERT, 2'd1, 16'd5,    1'b0, NO_BEAT},
      '{btk_pkg::FUNC_INSERT, 2'd1, 16'd3,    1'b0, NO_BEAT},
      '{btk_pkg::FUNC_INSERT, 2'd1, 16'd9,    1'b0, NO_BEAT},
      '{btk_pkg::FUNC_INSERT, 2'd1, 16'd3,    1'b0, NO_BEAT},
      '{btk_pkg::FUNC_INSERT, 2'd1, 16'd1,    1'b0, NO_BEAT},
      '{btk_pkg::FUNC_INSERT, 2'd1, 16'd7,    1'b0, NO_BEAT},
      '{btk_pkg::FUNC_INSERT, 2'd1, 16'h8000, 1'b0, NO_BEAT},
      '{btk_pkg::FUNC_INSERT, 2'd1, 16'd2,    1'b0, NO_BEAT},
      '{btk_pkg::FUNC_INSERT, 2'd1, 16'd4,    1'b0, NO_BEAT},
      '{btk_pkg::FUNC_INSERT, 2'd1, 16'd100,  1'b0, NO_BEAT},
      '{btk_pkg::FUNC_INSERT, 2'd1, 16'h8000, 1'b0, NO_BEAT},
      '{btk_pkg::FUNC_INSERT, 2'd1, 16'h0000, 1'b0, NO_BEAT},
      '{btk_pkg::FUNC_LIST,   2'd1, 16'h0000, 1'b0, NO_BEAT},
      '{btk_pkg::FUNC_INSERT, 2'd3, 16'hAAAA, 1'b0, NO_BEAT},
      '{btk_pkg::FUNC_LIST,   2'd3, 16'h5555, 1'b1, '{16'hAAAA, 4'd1, 1'b0, 1'b1}}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      offer_beat(dir_rows[i].func, dir_rows[i].mode, dir_rows[i].tv,
                 dir_rows[i].typed, dir_rows[i].exp);

    // Random part: mostly inserts into live lists, a quarter listings, and a
    // little mode-0 noise.
    kept = 0;
    while (kept < RAND_ITEMS) begin
      steady <= (kept >= 200 && kept < 300);
      if (kept == 60) hold_req <= 1'b1;
      m = ($urandom_range(0, 99) < 8) ? 2'd0 : btk_pkg::MODE_W'($urandom_range(1, LISTS));
      f = ($urandom_range(0, 99) < 25) ? btk_pkg::FUNC_LIST : btk_pkg::FUNC_INSERT;
      sel = (m == 0) ? 0 : int'(m) - 1;
      case ($urandom_range(0, 9))
        0, 1, 2: t = btk_pkg::TIME_W'($urandom_range(0, 65535));
        3, 4, 5: t = btk_pkg::TIME_W'($urandom_range(0, 255));
        6: begin
          case ($urandom_range(0, 3))
            0:       t = 16'h0000;
            1:       t = 16'hFFFF;
            2:       t = 16'h8000;
            default: t = 16'h7FFF;
          endcase
        end
        default: begin
          // aim at the largest stored time: one below, equal, one above
          if (ladder_cnt[sel] > 0) begin
            top = int'(ladder_tab[sel][ladder_cnt[sel]-1]) + $urandom_range(0, 2) - 1;
            if (top < 0) top = 0;
            if (top > 65535) top = 65535;
            t = btk_pkg::TIME_W'(top);
          end else begin
            t = btk_pkg::TIME_W'($urandom_range(0, 15));
          end
        end
      endcase
      offer_beat(f, m, t, 1'b0, NO_BEAT);
      kept++;
    end
    in_valid_i <= 1'b0;
    steady     <= 1'b0;

    // Drain: wait for every owed beat, then give the block room to misbehave.
    while (listing_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    if (mismatch_cnt == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/btk_pkg.sv
rtl/btk_ram.sv
rtl/best_times_top_k.sv
bench/tb_best_times_top_k.sv
